@@ rtl/crpi_pkg.sv @@
// Shared types, codes and helpers for the CMOS RAM port interface.
`default_nettype none

package crpi_pkg;

	// Bus operation codes
	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_READ   = 2'd1,
		OP_RELOAD = 2'd2
	} op_t;

	// Port select on writes
	typedef enum logic {
		PORT_INDEX = 1'b0,
		PORT_DATA  = 1'b1
	} port_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_FLOPPY_COUNT  = 3'd0,
		CFG_FLOPPY_TYPE0  = 3'd1,
		CFG_FLOPPY_TYPE1  = 3'd2,
		CFG_COPROC        = 3'd3,
		CFG_HDISK_COUNT   = 3'd4,
		CFG_BASE_KB       = 3'd5,
		CFG_XMS_KB        = 3'd6,
		CFG_EMS_KB        = 3'd7
	} cfg_reg_t;

	localparam int ADDR_W    = 6;
	localparam int RAM_DEPTH = 1 << ADDR_W;
	localparam int CFG_W     = 24;

	// Address map
	localparam logic [ADDR_W-1:0] ADDR_SEC       = 6'h00;
	localparam logic [ADDR_W-1:0] ADDR_MIN       = 6'h02;
	localparam logic [ADDR_W-1:0] ADDR_HOUR      = 6'h04;
	localparam logic [ADDR_W-1:0] ADDR_WDAY      = 6'h06;
	localparam logic [ADDR_W-1:0] ADDR_MDAY      = 6'h07;
	localparam logic [ADDR_W-1:0] ADDR_MONTH     = 6'h08;
	localparam logic [ADDR_W-1:0] ADDR_YEAR      = 6'h09;
	localparam logic [ADDR_W-1:0] ADDR_STAT_A    = 6'h0a;
	localparam logic [ADDR_W-1:0] ADDR_STAT_B    = 6'h0b;
	localparam logic [ADDR_W-1:0] ADDR_STAT_C    = 6'h0c;
	localparam logic [ADDR_W-1:0] ADDR_STAT_D    = 6'h0d;
	localparam logic [ADDR_W-1:0] ADDR_SHUTDOWN  = 6'h0f;
	localparam logic [ADDR_W-1:0] ADDR_CHK_HI    = 6'h2e;
	localparam logic [ADDR_W-1:0] ADDR_CHK_LO    = 6'h2f;
	localparam logic [ADDR_W-1:0] ADDR_EXT_MB_LO = 6'h30;
	localparam logic [ADDR_W-1:0] ADDR_EXT_MB_HI = 6'h31;
	localparam logic [ADDR_W-1:0] ADDR_INFO      = 6'h33;

	// Checksummed block 0x10..0x20, held in flops
	localparam logic [ADDR_W-1:0] CHK_FIRST = 6'h10;
	localparam logic [ADDR_W-1:0] CHK_LAST  = 6'h20;
	localparam int CHK_CNT   = 17;
	localparam int CHK_OFF_W = $clog2(CHK_CNT);

	// Offsets within the checksummed block
	localparam int OFF_DISK     = 0;
	localparam int OFF_HDISK    = 2;
	localparam int OFF_EQUIP    = 4;
	localparam int OFF_BASE_LO  = 5;
	localparam int OFF_BASE_HI  = 6;
	localparam int OFF_EXT_LO   = 7;
	localparam int OFF_EXT_HI   = 8;
	localparam int OFF_HD0_TYPE = 9;
	localparam int OFF_HD1_TYPE = 10;

	// Default byte values
	localparam logic [7:0] DEF_STAT_A   = 8'h26;
	localparam logic [7:0] DEF_STAT_B   = 8'h02;
	localparam logic [7:0] DEF_STAT_D   = 8'h80;
	localparam logic [7:0] DEF_SHUTDOWN = 8'h06;
	localparam logic [7:0] DEF_INFO     = 8'he1;
	localparam logic [7:0] HD_TYPE_47   = 8'd47;
	localparam logic [7:0] HD_ONE       = 8'hf0;
	localparam logic [7:0] HD_TWO       = 8'hff;

	// Extended size in MB is KB / 1024
	localparam int PEXT_SHIFT = 10;
	localparam int PEXT_W     = CFG_W - PEXT_SHIFT;

	typedef logic [CHK_CNT-1:0][7:0] chk_arr_t;

	// Read stage: a ready byte, or take the RAM output
	typedef struct packed {
		logic       use_ram;
		logic [7:0] data;
	} rd_stage_t;

	// Time/date registers answer with the supplied clock byte
	function automatic logic is_clock_addr(input logic [ADDR_W-1:0] a);
		return (a == ADDR_SEC) || (a == ADDR_MIN) || (a == ADDR_HOUR) ||
			(a == ADDR_WDAY) || (a == ADDR_MDAY) || (a == ADDR_MONTH) ||
			(a == ADDR_YEAR);
	endfunction

	// Reload value of a byte outside the checksummed block
	function automatic logic [7:0] default_byte(input logic [ADDR_W-1:0] a,
			input logic [PEXT_W-1:0] pext);
		logic [15:0] pext_ext;
		logic [7:0]  res;
		pext_ext = 16'(pext);
		unique case (a)
			ADDR_STAT_A:    res = DEF_STAT_A;
			ADDR_STAT_B:    res = DEF_STAT_B;
			ADDR_STAT_D:    res = DEF_STAT_D;
			ADDR_SHUTDOWN:  res = DEF_SHUTDOWN;
			ADDR_EXT_MB_LO: res = pext_ext[7:0];
			ADDR_EXT_MB_HI: res = pext_ext[15:8];
			ADDR_INFO:      res = DEF_INFO;
			default:        res = 8'h00;
		endcase
		return res;
	endfunction

	// Full 16-bit sum of the checksummed block
	function automatic logic [15:0] chk_sum(input chk_arr_t b);
		logic [15:0] s;
		s = '0;
		for (int i = 0; i < CHK_CNT; i++) begin
			s = s + 16'(b[i]);
		end
		return s;
	endfunction

endpackage

`default_nettype wire

@@ rtl/cmos_ram_port_interface.sv @@
// CMOS RAM with index and data ports: top level.
//
// One bus access enters per item and a new item can be taken every clock
// while in_stall is low. Index and data writes and reloads take effect at
// the accepting edge and give no result. A read's byte passes through the
// read stage, with the registered read of the 64-byte RAM, and then the
// output register before it is on read_data. in_stall rises only while a
// read waits behind a stalled output. Bytes 0x10..0x20 live in flops with
// a running 16-bit checksum, so the checksum registers answer at once; a
// reload clears per-byte valid bits at the accepting edge, with no clearing
// pass. Config writes are always ready (cfg_ready is tied high).
`default_nettype none

module cmos_ram_port_interface (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// input channel
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [1:0]                     op,
	input  wire logic                           port_select,
	input  wire logic [7:0]                     write_data,
	input  wire logic [7:0]                     clock_byte,
	// result channel
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [7:0]                     read_data,
	// configuration channel
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [2:0]                     cfg_index,
	input  wire logic [crpi_pkg::CFG_W-1:0]     cfg_data
);

	import crpi_pkg::*;

	// configuration registers
	logic [1:0]  fcount_q;
	logic [3:0]  ftype0_q;
	logic [3:0]  ftype1_q;
	logic        coproc_q;
	logic [1:0]  hdcount_q;
	logic [15:0] base_kb_q;
	logic [23:0] xms_kb_q;
	logic [23:0] ems_kb_q;

	// store state
	logic [ADDR_W-1:0]    index_q;
	logic [RAM_DEPTH-1:0] valid_q;
	logic                 loaded_q;
	logic [PEXT_W-1:0]    pext_q;
	chk_arr_t             chk_bytes_q;
	logic [15:0]          checksum_q;

	// pipeline
	logic       rd_vld_s1;
	rd_stage_t  rd_s1;
	logic [7:0] ram_rdata;
	logic       out_valid_q;
	logic [7:0] read_data_q;

	logic                 accept;
	logic                 acc_write;
	logic                 acc_read;
	logic                 acc_reload;
	logic                 data_write;
	logic                 in_region;
	logic [CHK_OFF_W-1:0] chk_off;
	logic [7:0]           chk_old;
	logic                 advance;
	rd_stage_t            rd_next;

	// reload values
	logic [1:0]  fd;
	logic [1:0]  hd;
	logic [23:0] ext_kb;
	logic [7:0]  b_disk;
	logic [7:0]  b_equip;
	logic [7:0]  b_hdisk;
	logic [7:0]  b_hd1;
	chk_arr_t    chk_load;
	logic [15:0] sum_load;

	assign cfg_ready = 1'b1;

	// handshake
	assign advance    = rd_vld_s1 && (!out_valid_q || !out_stall);
	assign in_stall   = rd_vld_s1 && !advance;
	assign accept     = in_valid && !in_stall;
	assign acc_write  = accept && (op == OP_WRITE);
	assign acc_read   = accept && (op == OP_READ);
	assign acc_reload = accept && (op == OP_RELOAD);
	assign data_write = acc_write && (port_select == PORT_DATA) &&
		(index_q != ADDR_STAT_C) && (index_q != ADDR_STAT_D);

	// checksummed block lookup
	assign in_region = (index_q >= CHK_FIRST) && (index_q <= CHK_LAST);
	assign chk_off   = CHK_OFF_W'(index_q - CHK_FIRST);
	assign chk_old   = in_region ? chk_bytes_q[chk_off] : 8'h00;

	// reload defaults from the configuration
	always_comb begin
		fd      = (fcount_q == 2'd3) ? 2'd2 : fcount_q;
		hd      = (hdcount_q == 2'd3) ? 2'd2 : hdcount_q;
		ext_kb  = (xms_kb_q > ems_kb_q) ? xms_kb_q : ems_kb_q;
		b_disk  = {(fd >= 2'd1) ? ftype0_q : 4'h0, (fd >= 2'd2) ? ftype1_q : 4'h0};
		// bits 7..6 hold drive count minus one
		b_equip = (fd >= 2'd1) ? {1'b0, fd == 2'd2, 4'b0000, coproc_q, 1'b1}
			: {6'b000000, coproc_q, 1'b0};
		unique case (hd)
			2'd0:    b_hdisk = 8'h00;
			2'd1:    b_hdisk = HD_ONE;
			default: b_hdisk = HD_TWO;
		endcase
		b_hd1 = (hd == 2'd2) ? HD_TYPE_47 : 8'h00;

		chk_load               = '0;
		chk_load[OFF_DISK]     = b_disk;
		chk_load[OFF_HDISK]    = b_hdisk;
		chk_load[OFF_EQUIP]    = b_equip;
		chk_load[OFF_BASE_LO]  = base_kb_q[7:0];
		chk_load[OFF_BASE_HI]  = base_kb_q[15:8];
		chk_load[OFF_EXT_LO]   = ext_kb[7:0];
		chk_load[OFF_EXT_HI]   = ext_kb[15:8];
		chk_load[OFF_HD0_TYPE] = HD_TYPE_47;
		chk_load[OFF_HD1_TYPE] = b_hd1;

		sum_load = 16'(b_disk) + 16'(b_hdisk) + 16'(b_equip) +
			16'(base_kb_q[7:0]) + 16'(base_kb_q[15:8]) +
			16'(ext_kb[7:0]) + 16'(ext_kb[15:8]) + 16'(HD_TYPE_47) + 16'(b_hd1);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcount_q  <= 2'd1;
			ftype0_q  <= 4'd4;
			ftype1_q  <= 4'd0;
			coproc_q  <= 1'b0;
			hdcount_q <= 2'd0;
			base_kb_q <= 16'd640;
			xms_kb_q  <= '0;
			ems_kb_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FLOPPY_COUNT: fcount_q  <= cfg_data[1:0];
				CFG_FLOPPY_TYPE0: ftype0_q  <= cfg_data[3:0];
				CFG_FLOPPY_TYPE1: ftype1_q  <= cfg_data[3:0];
				CFG_COPROC:       coproc_q  <= cfg_data[0];
				CFG_HDISK_COUNT:  hdcount_q <= cfg_data[1:0];
				CFG_BASE_KB:      base_kb_q <= cfg_data[15:0];
				CFG_XMS_KB:       xms_kb_q  <= cfg_data[23:0];
				CFG_EMS_KB:       ems_kb_q  <= cfg_data[23:0];
				default:          ;
			endcase
		end
	end

	// index register, valid bits, checksummed block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_q     <= '0;
			valid_q     <= '0;
			loaded_q    <= 1'b0;
			pext_q      <= '0;
			chk_bytes_q <= '0;
			checksum_q  <= '0;
		end else begin
			if (acc_write && (port_select == PORT_INDEX)) begin
				index_q <= write_data[ADDR_W-1:0];
			end
			if (data_write) begin
				valid_q[index_q] <= 1'b1;
				if (in_region) begin
					chk_bytes_q[chk_off] <= write_data;
					checksum_q           <= checksum_q - 16'(chk_old) + 16'(write_data);
				end
			end
			if (acc_reload) begin
				valid_q     <= '0;
				loaded_q    <= 1'b1;
				pext_q      <= ext_kb[CFG_W-1:PEXT_SHIFT];
				chk_bytes_q <= chk_load;
				checksum_q  <= sum_load;
			end
		end
	end

	// byte store outside the flops
	crpi_ram #(
		.WIDTH(8),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (data_write),
		.waddr (index_q),
		.wdata (write_data),
		.re    (acc_read),
		.raddr (index_q),
		.rdata (ram_rdata)
	);

	// read source selection at acceptance
	always_comb begin
		rd_next.use_ram = 1'b0;
		priority if (is_clock_addr(index_q)) begin
			rd_next.data = clock_byte;
		end else if (index_q == ADDR_CHK_HI) begin
			rd_next.data = checksum_q[15:8];
		end else if (index_q == ADDR_CHK_LO) begin
			rd_next.data = checksum_q[7:0];
		end else if (in_region) begin
			rd_next.data = chk_old;
		end else if (valid_q[index_q]) begin
			rd_next.data    = 8'h00;
			rd_next.use_ram = 1'b1;
		end else begin
			rd_next.data = loaded_q ? default_byte(index_q, pext_q) : 8'h00;
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else if (acc_read) begin
			rd_vld_s1 <= 1'b1;
		end else if (advance) begin
			rd_vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_read) begin
			rd_s1 <= rd_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data_q <= rd_s1.use_ram ? ram_rdata : rd_s1.data;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;

	// checks
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid_q && out_stall && rd_vld_s1))
		else $error("input stalled without a blocked read");

	a_checksum: assert property (@(posedge clk) disable iff (!arst_n)
		checksum_q == chk_sum(chk_bytes_q))
		else $error("running checksum out of step with the block");

	a_ro_status: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_q[ADDR_STAT_C] && !valid_q[ADDR_STAT_D])
		else $error("read-only status register was written");

	a_read_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_vld_s1 && !out_stall) |=> out_valid_q)
		else $error("pending read not moved to the output");

	a_held_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(read_data_q)))
		else $error("stalled result changed");

endmodule

`default_nettype wire

@@ rtl/crpi_ram.sv @@
// Generic single-port-write, registered-read RAM.
`default_nettype none

module crpi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire
